/* rtl/voxel_turtle_interpreter_assert.svh */
// ----------------------------------------------------------------------------
// voxel turtle interpreter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef VOXEL_TURTLE_INTERPRETER_ASSERT_SVH
`define VOXEL_TURTLE_INTERPRETER_ASSERT_SVH

// same-cycle implication
`define VTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vti same-cycle check failed");

// next-cycle implication
`define VTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vti next-cycle check failed");

`endif

/* rtl/vti_pkg.sv */
// ----------------------------------------------------------------------------
// vti_pkg
// types, constants and helpers of the voxel turtle interpreter
// ----------------------------------------------------------------------------
`default_nettype none

package vti_pkg;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned OUT_BITS     = 16;
  localparam int unsigned CNT_BITS     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SYM_BITS     = 8;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned CHANCE_BITS  = 17;
  localparam int unsigned TYPE_BITS    = 8;
  localparam int unsigned STATUS_BITS  = 2;
  localparam int unsigned APB_DW       = 32;
  localparam int unsigned APB_AW       = 4;
  localparam int unsigned REG_IDX_BITS = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [1:0]            unit_t;
  typedef logic signed [OUT_BITS-1:0]   out_coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    unit_t  dx;
    unit_t  dy;
    unit_t  dz;
  } turtle_t;

  localparam turtle_t TurtleHome = '{
    x: '0, y: '1, z: '0, dx: 2'sd0, dy: 2'sd1, dz: 2'sd0
  };

  // symbols
  localparam logic [SYM_BITS-1:0] SymTrunk     = 8'h54;  // T
  localparam logic [SYM_BITS-1:0] SymTrunkOpt  = 8'h74;  // t
  localparam logic [SYM_BITS-1:0] SymLeaf      = 8'h4C;  // L
  localparam logic [SYM_BITS-1:0] SymLeafOpt   = 8'h6C;  // l
  localparam logic [SYM_BITS-1:0] SymPush      = 8'h5B;  // [
  localparam logic [SYM_BITS-1:0] SymPop       = 8'h5D;  // ]
  localparam logic [SYM_BITS-1:0] SymZPlus     = 8'h2B;  // +
  localparam logic [SYM_BITS-1:0] SymZMinus    = 8'h2D;  // -
  localparam logic [SYM_BITS-1:0] SymXPlus     = 8'h2A;  // *
  localparam logic [SYM_BITS-1:0] SymXMinus    = 8'h2F;  // /
  localparam logic [SYM_BITS-1:0] SymYPlus     = 8'h3E;  // >
  localparam logic [SYM_BITS-1:0] SymYMinus    = 8'h3C;  // <

  // result status
  localparam logic [STATUS_BITS-1:0] StatusPlaced    = 2'd0;
  localparam logic [STATUS_BITS-1:0] StatusOverflow  = 2'd1;
  localparam logic [STATUS_BITS-1:0] StatusUnderflow = 2'd2;

  // register indexes
  localparam logic [REG_IDX_BITS-1:0] RegTrunkType   = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] RegLeafType    = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] RegTrunkChance = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] RegLeafChance  = 2'd3;

  localparam logic [CHANCE_BITS-1:0] ChanceReset = 17'h10000;

  typedef struct packed {
    logic [TYPE_BITS-1:0]   trunk_type;
    logic [TYPE_BITS-1:0]   leaf_type;
    logic [CHANCE_BITS-1:0] trunk_chance;
    logic [CHANCE_BITS-1:0] leaf_chance;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  typedef struct packed {
    out_coord_t             pos_x;
    out_coord_t             pos_y;
    out_coord_t             pos_z;
    logic [TYPE_BITS-1:0]   block_type;
    logic [STATUS_BITS-1:0] status;
  } cube_t;

  function automatic out_coord_t coord_out(coord_t v);
    return OUT_BITS'(v);
  endfunction

  function automatic coord_t coord_step(coord_t p, unit_t d);
    return p + COORD_BITS'(d);
  endfunction

endpackage

`default_nettype wire

/* rtl/vti_if.sv */
// ----------------------------------------------------------------------------
// vti channel interfaces
// symbol request channel and cube result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface vti_sym_if;
  import vti_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SYM_BITS-1:0]    symbol;
  logic [SAMPLE_BITS-1:0] random_sample;
  logic                   new_tree;

  modport source (output valid, symbol, random_sample, new_tree, input ready);
  modport sink   (input valid, symbol, random_sample, new_tree, output ready);
endinterface

interface vti_cube_if;
  import vti_pkg::*;

  logic                   valid;
  logic                   ready;
  out_coord_t             pos_x;
  out_coord_t             pos_y;
  out_coord_t             pos_z;
  logic [TYPE_BITS-1:0]   block_type;
  logic [STATUS_BITS-1:0] status;

  modport source (output valid, pos_x, pos_y, pos_z, block_type, status, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, block_type, status, output ready);
endinterface

`default_nettype wire

/* rtl/vti_cell.sv */
// ----------------------------------------------------------------------------
// vti_cell
// one slot of the shifting turtle stack, loads from above on push and
// from below on pop
// ----------------------------------------------------------------------------
`default_nettype none

module vti_cell (
  input  logic                 clk_i,
  input  vti_pkg::stack_ctl_t  ctl_i,
  input  vti_pkg::turtle_t     up_i,
  input  vti_pkg::turtle_t     down_i,
  output vti_pkg::turtle_t     entry_o
);
  import vti_pkg::*;

  turtle_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      entry_q <= up_i;
    end else if (ctl_i.pop) begin
      entry_q <= down_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

/* rtl/vti_turtle.sv */
// ----------------------------------------------------------------------------
// vti_turtle
// turtle position, direction and stack fill, symbol decode and cube result
// ----------------------------------------------------------------------------
`default_nettype none

module vti_turtle (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [vti_pkg::SYM_BITS-1:0]       symbol_i,
  input  logic [vti_pkg::SAMPLE_BITS-1:0]    random_sample_i,
  input  logic                               new_tree_i,
  input  vti_pkg::cfg_t                      cfg_i,
  input  vti_pkg::turtle_t                   top_i,
  output vti_pkg::turtle_t                   turtle_o,
  output vti_pkg::stack_ctl_t                ctl_o,
  output logic                               res_valid_o,
  output vti_pkg::cube_t                     res_o
);
  import vti_pkg::*;

  turtle_t             turtle_q, turtle_d, cur, stepped;
  logic [CNT_BITS-1:0] count_q, count_d, cnt;
  logic [CNT_BITS-1:0] cnt_minus;
  logic                trunk_hit, leaf_hit, full, empty;
  logic                res_valid;
  cube_t               res;
  stack_ctl_t          ctl;

  assign cur       = new_tree_i ? TurtleHome : turtle_q;
  assign cnt       = new_tree_i ? '0 : count_q;
  assign cnt_minus = cnt - CNT_BITS'(1);
  assign full      = (cnt == CNT_BITS'(STACK_DEPTH));
  assign empty     = (cnt == '0);
  assign trunk_hit = ({1'b0, random_sample_i} < cfg_i.trunk_chance);
  assign leaf_hit  = ({1'b0, random_sample_i} < cfg_i.leaf_chance);

  always_comb begin
    stepped   = cur;
    stepped.x = coord_step(cur.x, cur.dx);
    stepped.y = coord_step(cur.y, cur.dy);
    stepped.z = coord_step(cur.z, cur.dz);
  end

  always_comb begin
    turtle_d   = cur;
    count_d    = cnt;
    ctl        = '0;
    res_valid  = 1'b0;
    res.pos_x  = coord_out(cur.x);
    res.pos_y  = coord_out(cur.y);
    res.pos_z  = coord_out(cur.z);
    res.block_type = '0;
    res.status = StatusPlaced;
    unique case (symbol_i)
      SymTrunk, SymTrunkOpt, SymLeaf, SymLeafOpt: begin
        if (symbol_i == SymTrunk || symbol_i == SymLeaf ||
            (symbol_i == SymTrunkOpt && trunk_hit) ||
            (symbol_i == SymLeafOpt && leaf_hit)) begin
          turtle_d   = stepped;
          res_valid  = 1'b1;
          res.pos_x  = coord_out(stepped.x);
          res.pos_y  = coord_out(stepped.y);
          res.pos_z  = coord_out(stepped.z);
          res.block_type = (symbol_i == SymTrunk || symbol_i == SymTrunkOpt) ?
                           cfg_i.trunk_type : cfg_i.leaf_type;
        end
      end
      SymPush: begin
        if (full) begin
          res_valid  = 1'b1;
          res.status = StatusOverflow;
        end else begin
          ctl.push = 1'b1;
          count_d  = cnt + CNT_BITS'(1);
        end
      end
      SymPop: begin
        if (empty) begin
          res_valid  = 1'b1;
          res.status = StatusUnderflow;
        end else begin
          ctl.pop  = 1'b1;
          count_d  = cnt_minus;
          turtle_d = top_i;
        end
      end
      SymZPlus: begin
        turtle_d.dx = -cur.dy;
        turtle_d.dy = cur.dx;
      end
      SymZMinus: begin
        turtle_d.dy = -cur.dx;
        turtle_d.dx = cur.dy;
      end
      SymXPlus: begin
        turtle_d.dy = -cur.dz;
        turtle_d.dz = cur.dy;
      end
      SymXMinus: begin
        turtle_d.dz = -cur.dy;
        turtle_d.dy = cur.dz;
      end
      SymYPlus: begin
        turtle_d.dz = -cur.dx;
        turtle_d.dx = cur.dz;
      end
      SymYMinus: begin
        turtle_d.dx = -cur.dz;
        turtle_d.dz = cur.dx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turtle_q <= TurtleHome;
      count_q  <= '0;
    end else if (accept_i) begin
      turtle_q <= turtle_d;
      count_q  <= count_d;
    end
  end

  // push loads the current turtle, with a new tree applied
  assign turtle_o    = cur;
  assign ctl_o.push  = ctl.push & accept_i;
  assign ctl_o.pop   = ctl.pop & accept_i;
  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule

`default_nettype wire

/* rtl/voxel_turtle_interpreter.sv */
// ----------------------------------------------------------------------------
// voxel_turtle_interpreter
// 3-d turtle interpreter for l-system symbols with a shifting turtle stack
// ----------------------------------------------------------------------------
// Usage: symbol requests enter on sym_in (symbol, random_sample, new_tree)
// with a valid/ready handshake. Each request gives zero or one cube result
// on cube_out: a placed cube (status 0) for T, L and taken t, l steps, or
// an overflow (status 1) or underflow (status 2) report for [ and ].
// Registers are written over the APB port: 0 trunk type, 1 leaf type,
// 2 trunk chance, 3 leaf chance, at byte addresses 0, 4, 8 and 12.
// Each result is registered: it is on cube_out the cycle after acceptance.
// Throughput: one request per cycle unless stalled; the turtle update, one
// decode and add stage and one stack cell chain shift all fit in that cycle.
// Stall: while cube_out holds a result that is not taken, sym_in.ready is
// low; a taken result lets a new request in the same cycle.
// Reset: turtle at (0, -1, 0) facing +y, stack empty, types 0, chances
// 65536. The stack cells need no clearing, only filled slots are read.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_turtle_interpreter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vti_pkg::APB_AW-1:0]     paddr,
  input  logic [vti_pkg::APB_DW-1:0]     pwdata,
  output logic [vti_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  vti_sym_if.sink                        sym_in,
  vti_cube_if.source                     cube_out
);
  import vti_pkg::*;

  cfg_t                  cfg_q;
  logic                  cfg_we;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                  accept;
  logic                  out_valid_q;
  cube_t                 cube_q;
  logic                  res_valid;
  cube_t                 res;
  stack_ctl_t            ctl;
  turtle_t               turtle;
  turtle_t               stack_q [STACK_DEPTH];

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trunk_type   <= '0;
      cfg_q.leaf_type    <= '0;
      cfg_q.trunk_chance <= ChanceReset;
      cfg_q.leaf_chance  <= ChanceReset;
    end else if (cfg_we) begin
      unique case (reg_idx)
        RegTrunkType:   cfg_q.trunk_type   <= pwdata[TYPE_BITS-1:0];
        RegLeafType:    cfg_q.leaf_type    <= pwdata[TYPE_BITS-1:0];
        RegTrunkChance: cfg_q.trunk_chance <= pwdata[CHANCE_BITS-1:0];
        RegLeafChance:  cfg_q.leaf_chance  <= pwdata[CHANCE_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegTrunkType:   prdata = APB_DW'(cfg_q.trunk_type);
      RegLeafType:    prdata = APB_DW'(cfg_q.leaf_type);
      RegTrunkChance: prdata = APB_DW'(cfg_q.trunk_chance);
      RegLeafChance:  prdata = APB_DW'(cfg_q.leaf_chance);
    endcase
  end

  // request handshake
  assign sym_in.ready = ~out_valid_q | cube_out.ready;
  assign accept       = sym_in.valid & sym_in.ready;

  vti_turtle u_turtle (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .symbol_i        (sym_in.symbol),
    .random_sample_i (sym_in.random_sample),
    .new_tree_i      (sym_in.new_tree),
    .cfg_i           (cfg_q),
    .top_i           (stack_q[0]),
    .turtle_o        (turtle),
    .ctl_o           (ctl),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // stack cell chain, slot 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    turtle_t up, down;
    if (i == 0) begin : g_head
      assign up = turtle;
    end else begin : g_body
      assign up = stack_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign down = stack_q[i];
    end else begin : g_mid
      assign down = stack_q[i+1];
    end
    vti_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .up_i    (up),
      .down_i  (down),
      .entry_o (stack_q[i])
    );
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= res_valid;
    end else if (cube_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      cube_q <= res;
    end
  end

  assign cube_out.valid      = out_valid_q;
  assign cube_out.pos_x      = cube_q.pos_x;
  assign cube_out.pos_y      = cube_q.pos_y;
  assign cube_out.pos_z      = cube_q.pos_z;
  assign cube_out.block_type = cube_q.block_type;
  assign cube_out.status     = cube_q.status;

endmodule

`default_nettype wire

/* rtl/vti_checker.sv */
// ----------------------------------------------------------------------------
// vti_checker
// port-level checks of the voxel turtle interpreter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_turtle_interpreter_assert.svh"

module vti_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [vti_pkg::TYPE_BITS-1:0]       out_block_type_i,
  input  logic [vti_pkg::STATUS_BITS-1:0]     out_status_i
);
  import vti_pkg::*;

  logic stalled;

  assign stalled = out_valid_i & ~out_ready_i;

  `VTI_ASSERT_NXT(a_stall_holds_valid, clk_i, rst_ni, stalled, out_valid_i)
  `VTI_ASSERT_NXT(a_stall_holds_status, clk_i, rst_ni, stalled, $stable(out_status_i))
  `VTI_ASSERT_IMP(a_error_type_zero, clk_i, rst_ni, out_valid_i && out_status_i != StatusPlaced, out_block_type_i == '0)
  `VTI_ASSERT_IMP(a_ready_follows_out, clk_i, rst_ni, 1'b1, in_ready_i == (!out_valid_i || out_ready_i))

endmodule

bind voxel_turtle_interpreter vti_checker u_vti_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (sym_in.valid),
  .in_ready_i       (sym_in.ready),
  .out_valid_i      (cube_out.valid),
  .out_ready_i      (cube_out.ready),
  .out_block_type_i (cube_out.block_type),
  .out_status_i     (cube_out.status)
);

`default_nettype wire
